// ===== rtl/core/decimal_metres_to_millimetres_assert.svh =====
// assertion macros for the checker file
`ifndef DECIMAL_METRES_TO_MILLIMETRES_ASSERT_SVH
`define DECIMAL_METRES_TO_MILLIMETRES_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DMM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dmm_pkg.sv =====
package dmm_pkg;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_SIGN_ONLY = 3'd2,
		ST_TOO_BIG   = 3'd3,
		ST_BAD       = 3'd4
	} status_t;

	// parser phase, one-hot
	typedef enum logic [3:0] {
		PH_LEAD = 4'b0001,
		PH_SIGN = 4'b0010,
		PH_INT  = 4'b0100,
		PH_FRAC = 4'b1000
	} phase_t;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// arithmetic constants
	localparam logic [26:0] WHOLE_LIMIT = 27'd10000000;
	localparam logic [36:0] MM_PER_M    = 37'd1000;
	localparam logic [3:0]  ROUND_DIGIT = 4'd5;
	localparam logic [2:0]  FRAC_KEEP   = 3'd3;
	localparam logic [2:0]  FRAC_SAT    = 3'd4;

	// input beat
	typedef struct packed {
		logic [7:0] character;
		logic       has_character;
		logic       is_last;
	} char_beat_t;

	// result beat
	typedef struct packed {
		logic signed [37:0] millimetres;
		status_t            status;
	} result_beat_t;

	// running parser state
	typedef struct packed {
		phase_t      phase;
		logic        is_negative;
		logic [26:0] whole_part;
		logic [9:0]  fraction_part;
		logic [2:0]  fraction_digits_taken;
		logic        round_up;
		logic        pending_blank;
		status_t     error_code;
	} parse_t;

	localparam parse_t PARSE_INIT = '{
		phase: PH_LEAD,
		is_negative: 1'b0,
		whole_part: 27'd0,
		fraction_part: 10'd0,
		fraction_digits_taken: 3'd0,
		round_up: 1'b0,
		pending_blank: 1'b0,
		error_code: ST_OK
	};

endpackage

// ===== rtl/core/decimal_metres_to_millimetres.sv =====
// decimal metres text to signed millimetres
//
// char channel (char_valid / char_ready / char_beat): one byte of text per
// beat, in order. has_character = 0 gives a beat with no byte; is_last ends
// the text. Every beat updates the running parse state as it is accepted.
// result channel (result_valid / result_ready / result_beat): one result beat
// per text, produced by the beat with is_last set.
// Throughput: one char beat per cycle while char_ready is high, including
// back-to-back texts. Each byte costs one multiply-by-ten accumulate in the
// parse state. Result path: the edge that accepts the last char beat
// captures the final state and padded fraction in stage 1; once the output
// register is free, whole * 1000 + fraction with the sign is loaded into
// it.
// Stall: while result_ready is low the result beat holds; one further final
// state waits in stage 1, after which char_ready drops until the output drains.
// Reset (arst_n low): the parse state returns to the leading-blank phase,
// both pipeline stages empty, char_ready stays high through and after reset.
module decimal_metres_to_millimetres
	import dmm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         char_valid,
	output logic         char_ready,
	input  char_beat_t   char_beat,
	output logic         result_valid,
	input  logic         result_ready,
	output result_beat_t result_beat
);

	parse_t      parse_q;
	parse_t      parse_nxt;

	logic        valid_s1;
	logic [26:0] whole_s1;
	logic [9:0]  frac_s1;
	logic        neg_s1;
	status_t     status_s1;

	logic        valid_s2;
	logic [37:0] mm_s2;
	status_t     status_s2;

	logic        ready_s2;
	logic        accept;

	logic [7:0]  c;
	logic [3:0]  d;
	logic        is_blank;
	logic        is_digit;
	logic        is_mark;
	logic        is_sign;
	logic [9:0]  frac_x10;
	logic [26:0] whole_x10;

	status_t     final_status;
	logic [9:0]  frac_pad;
	logic [36:0] mag_s2;

	// handshake
	assign ready_s2   = !valid_s2 || result_ready;
	assign char_ready = !valid_s1 || ready_s2;
	assign accept     = char_valid && char_ready;

	// character classes
	assign c        = char_beat.character;
	assign d        = c[3:0];
	assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_mark  = (c == CH_DOT) || (c == CH_COMMA);
	assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);

	// times ten as shifts, values stay in range where used
	assign frac_x10  = 10'({parse_q.fraction_part, 3'b000}) + 10'({parse_q.fraction_part, 1'b0});
	assign whole_x10 = 27'({parse_q.whole_part, 3'b000}) + 27'({parse_q.whole_part, 1'b0});

	// next parse state for this beat
	always_comb begin
		parse_nxt = parse_q;
		if (char_beat.has_character && (parse_q.error_code == ST_OK)) begin
			priority if (is_blank) begin
				// leading space or tab is skipped, anything else starts a blank run
				if (!((parse_q.phase == PH_LEAD) && (c != CH_CR) && !parse_q.pending_blank)) begin
					parse_nxt.pending_blank = 1'b1;
				end
			end else if (parse_q.pending_blank) begin
				parse_nxt.error_code = ST_BAD;
			end else if ((parse_q.phase == PH_LEAD) && is_sign) begin
				parse_nxt.is_negative = (c == CH_MINUS);
				parse_nxt.phase       = PH_SIGN;
			end else if (parse_q.phase == PH_FRAC) begin
				if (!is_digit) begin
					parse_nxt.error_code = ST_BAD;
				end else begin
					// keep three digits, the fourth decides rounding
					if (parse_q.fraction_digits_taken < FRAC_KEEP) begin
						parse_nxt.fraction_part = frac_x10 + 10'(d);
					end else if (parse_q.fraction_digits_taken == FRAC_KEEP) begin
						parse_nxt.round_up = (d >= ROUND_DIGIT);
					end
					if (parse_q.fraction_digits_taken < FRAC_SAT) begin
						parse_nxt.fraction_digits_taken = parse_q.fraction_digits_taken + 3'd1;
					end
				end
			end else if (is_digit) begin
				if (parse_q.whole_part > WHOLE_LIMIT) begin
					parse_nxt.error_code = ST_TOO_BIG;
				end else begin
					parse_nxt.whole_part = whole_x10 + 27'(d);
					parse_nxt.phase      = PH_INT;
				end
			end else if (is_mark) begin
				parse_nxt.phase = PH_FRAC;
			end else begin
				parse_nxt.error_code = ST_BAD;
			end
		end
	end

	// status of the text as it ends
	always_comb begin
		priority if (parse_nxt.error_code != ST_OK) begin
			final_status = parse_nxt.error_code;
		end else if (parse_nxt.phase == PH_LEAD) begin
			final_status = ST_EMPTY;
		end else if (parse_nxt.phase == PH_SIGN) begin
			final_status = ST_SIGN_ONLY;
		end else begin
			final_status = ST_OK;
		end
	end

	// pad fraction to thousandths and add the rounding bit
	always_comb begin
		unique case (parse_nxt.fraction_digits_taken)
			3'd0: frac_pad = 10'd0;
			3'd1: frac_pad = 10'(14'(parse_nxt.fraction_part) * 14'd100);
			3'd2: frac_pad = 10'(14'(parse_nxt.fraction_part) * 14'd10);
			default: frac_pad = parse_nxt.fraction_part;
		endcase
		frac_pad = frac_pad + 10'(parse_nxt.round_up);
	end

	// parse state, cleared after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q <= PARSE_INIT;
		end else if (accept) begin
			parse_q <= char_beat.is_last ? PARSE_INIT : parse_nxt;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (accept && char_beat.is_last) || (valid_s1 && !ready_s2);
		end
	end

	// stage 1 payload: final state of the text
	always_ff @(posedge clk) begin
		if (accept && char_beat.is_last) begin
			whole_s1  <= parse_nxt.whole_part;
			frac_s1   <= frac_pad;
			neg_s1    <= parse_nxt.is_negative;
			status_s1 <= final_status;
		end
	end

	// stage 2 value: whole * 1000 + fraction
	assign mag_s2 = 37'(whole_s1) * MM_PER_M + 37'(frac_s1);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// output register payload, zero unless ok
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			status_s2 <= status_s1;
			if (status_s1 != ST_OK) begin
				mm_s2 <= 38'd0;
			end else if (neg_s1) begin
				mm_s2 <= 38'd0 - 38'(mag_s2);
			end else begin
				mm_s2 <= 38'(mag_s2);
			end
		end
	end

	assign result_valid            = valid_s2;
	assign result_beat.millimetres = $signed(mm_s2);
	assign result_beat.status      = status_s2;

endmodule

// ===== rtl/core/dmm_checker.sv =====
`include "decimal_metres_to_millimetres_assert.svh"

// port-level checks on the converter
module dmm_checker
	import dmm_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         char_valid,
	input logic         char_ready,
	input char_beat_t   char_beat,
	input logic         result_valid,
	input logic         result_ready,
	input result_beat_t result_beat
);

	// a stalled result beat holds
	`DMM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_beat), "result beat changed while stalled")

	// error results carry zero
	`DMM_ASSERT_NOW(a_err_zero, result_valid && (result_beat.status != ST_OK), result_beat.millimetres == 38'sd0, "nonzero value on error status")

	// value stays within the representable text range
	`DMM_ASSERT_NOW(a_mm_range, result_valid, (result_beat.millimetres <= 38'sd100000010000) && (result_beat.millimetres >= -38'sd100000010000), "millimetres out of range")

	// with the output empty the input side is never blocked
	`DMM_ASSERT_NOW(a_ready_when_empty, !result_valid, char_ready, "char_ready low with empty output")

endmodule

bind decimal_metres_to_millimetres dmm_checker u_dmm_checker (.*);
